// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Used by tcw_ctrl, tcw_datapath and text_console_writer_top; no dependencies.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;

    localparam int NCELLS     = ROWS * COLUMNS;
    localparam int COPY_CELLS = NCELLS - COLUMNS;

    // Field widths of the channels
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CHAR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;

    // Internal widths
    localparam int ADDR_W    = $clog2(NCELLS);
    localparam int IDX_W     = $clog2(NCELLS + 1);
    localparam int COL_SUM_W = $clog2(COLUMNS + TAB_STOP);
    localparam int PH_W      = $clog2(TAB_STOP);

    localparam logic FUNC_PUT   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

    typedef struct packed {
        logic              func;
        logic [CHAR_W-1:0] char_code;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [POS_W-1:0]  cursor_pos;
        logic              cell_written;
        logic [POS_W-1:0]  write_addr;
        logic [CELL_W-1:0] write_data;
        logic              scrolled;
    } out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CALC,
        ST_CLEAR,
        ST_SCROLL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;      // capture the input item
        logic calc;        // update cursor, store character, latch result
        logic sweep_run;   // walk the cell store
        logic sweep_copy;  // walk moves each line up one row
        logic sweep_init;  // walk fills with the reset blank
        logic load_out;    // move latched result to the output register
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic need_scroll;
        logic sweep_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/tcw_datapath.sv =====
// Datapath of the text console writer: cursor, attribute, cell store,
// store sweep pipeline and output register. Depends on tcw_pkg.
`default_nettype none

module tcw_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire tcw_pkg::cmd_t               cmd,
    output tcw_pkg::sts_t                    sts,
    input  wire tcw_pkg::in_t                s_data,
    input  wire logic                        cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output tcw_pkg::out_t                    m_data
);

    tcw_pkg::in_t                      in_reg;
    logic [tcw_pkg::ATTR_W-1:0]        attr_reg;
    logic [tcw_pkg::ROW_W-1:0]         row_reg,   row_next;
    logic [tcw_pkg::COL_W-1:0]         col_reg,   col_next;
    logic [tcw_pkg::PH_W-1:0]          phase_reg, phase_next;
    tcw_pkg::out_t                     res_reg,   res_next;
    tcw_pkg::out_t                     out_reg;
    logic                              m_valid_reg;

    logic [tcw_pkg::CELL_W-1:0]        mem [tcw_pkg::NCELLS];
    logic [tcw_pkg::CELL_W-1:0]        rd_data_reg;
    logic [tcw_pkg::IDX_W-1:0]         idx_reg;
    logic                              pend_valid_reg;
    logic                              pend_copy_reg;
    logic [tcw_pkg::ADDR_W-1:0]        pend_addr_reg;

    logic [tcw_pkg::COL_SUM_W-1:0]     col_sum;
    logic [tcw_pkg::PH_W-1:0]          ph_sum;
    logic [tcw_pkg::ROW_W:0]           row_sum;
    logic                              wr_flag;
    logic                              need_scroll;
    logic                              char_we;
    logic [tcw_pkg::ADDR_W-1:0]        old_pos;
    logic [tcw_pkg::ADDR_W-1:0]        new_pos;
    logic [tcw_pkg::CELL_W-1:0]        cell_data;
    logic [tcw_pkg::CELL_W-1:0]        fill_data;
    logic                              rd_en;
    logic [tcw_pkg::ADDR_W-1:0]        rd_addr;
    logic                              sweep_last;

    // Cursor step for a put item
    always_comb begin
        col_sum = tcw_pkg::COL_SUM_W'(col_reg);
        ph_sum  = phase_reg;
        row_sum = {1'b0, row_reg};
        wr_flag = 1'b0;
        priority if (in_reg.char_code == tcw_pkg::CH_BS) begin
            if (col_reg != '0) begin
                col_sum = tcw_pkg::COL_SUM_W'(col_reg) - tcw_pkg::COL_SUM_W'(1);
                ph_sum  = (phase_reg == '0) ? tcw_pkg::PH_W'(tcw_pkg::TAB_STOP - 1)
                                            : phase_reg - tcw_pkg::PH_W'(1);
            end
        end else if (in_reg.char_code == tcw_pkg::CH_TAB) begin
            col_sum = tcw_pkg::COL_SUM_W'(col_reg) + tcw_pkg::COL_SUM_W'(tcw_pkg::TAB_STOP)
                      - tcw_pkg::COL_SUM_W'(phase_reg);
            ph_sum  = '0;
        end else if (in_reg.char_code == tcw_pkg::CH_CR) begin
            col_sum = '0;
            ph_sum  = '0;
        end else if (in_reg.char_code == tcw_pkg::CH_LF) begin
            col_sum = '0;
            ph_sum  = '0;
            row_sum = {1'b0, row_reg} + (tcw_pkg::ROW_W + 1)'(1);
        end else if (in_reg.char_code >= tcw_pkg::CH_SPACE) begin
            wr_flag = 1'b1;
            col_sum = tcw_pkg::COL_SUM_W'(col_reg) + tcw_pkg::COL_SUM_W'(1);
            ph_sum  = (phase_reg == tcw_pkg::PH_W'(tcw_pkg::TAB_STOP - 1))
                      ? '0 : phase_reg + tcw_pkg::PH_W'(1);
        end else begin
            wr_flag = 1'b0;
        end
        // column wrap
        if (col_sum >= tcw_pkg::COL_SUM_W'(tcw_pkg::COLUMNS)) begin
            col_sum = '0;
            ph_sum  = '0;
            row_sum = row_sum + (tcw_pkg::ROW_W + 1)'(1);
        end
    end

    assign need_scroll = (in_reg.func == tcw_pkg::FUNC_PUT) &&
                         (row_sum >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS));

    always_comb begin
        if (in_reg.func == tcw_pkg::FUNC_CLEAR) begin
            row_next   = '0;
            col_next   = '0;
            phase_next = '0;
        end else begin
            row_next   = need_scroll ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
                                     : row_sum[tcw_pkg::ROW_W-1:0];
            col_next   = tcw_pkg::COL_W'(col_sum);
            phase_next = ph_sum;
        end
    end

    assign old_pos = tcw_pkg::ADDR_W'(row_reg) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                     + tcw_pkg::ADDR_W'(col_reg);
    assign new_pos = tcw_pkg::ADDR_W'(row_next) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
                     + tcw_pkg::ADDR_W'(col_next);
    assign cell_data = {attr_reg, in_reg.char_code};
    assign char_we   = cmd.calc && (in_reg.func == tcw_pkg::FUNC_PUT) && wr_flag;

    always_comb begin
        res_next.cursor_row   = row_next;
        res_next.cursor_col   = col_next;
        res_next.cursor_pos   = tcw_pkg::POS_W'(new_pos);
        res_next.cell_written = char_we;
        res_next.write_addr   = char_we ? tcw_pkg::POS_W'(old_pos) : '0;
        res_next.write_data   = char_we ? cell_data : '0;
        res_next.scrolled     = need_scroll;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg  <= tcw_pkg::RESET_ATTR;
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= '0;
        end else begin
            if (cfg_we) begin
                attr_reg <= cfg_wdata;
            end
            if (cmd.calc) begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_reg <= s_data;
        end
        if (cmd.calc) begin
            res_reg <= res_next;
        end
        if (cmd.load_out) begin
            out_reg <= res_reg;
        end
    end

    // Store sweep: for a copy, cell idx+COLUMNS is read into rd_data_reg and written at idx in the cycle after.
    // For a scroll, cell idx takes cell idx+COLUMNS; the last line takes blanks.
    assign sweep_last = (idx_reg == tcw_pkg::IDX_W'(tcw_pkg::NCELLS));
    assign rd_en      = cmd.sweep_run && cmd.sweep_copy &&
                        (idx_reg < tcw_pkg::IDX_W'(tcw_pkg::COPY_CELLS));
    assign rd_addr    = tcw_pkg::ADDR_W'(idx_reg + tcw_pkg::IDX_W'(tcw_pkg::COLUMNS));
    assign fill_data  = cmd.sweep_init ? tcw_pkg::RESET_CELL : {attr_reg, tcw_pkg::CH_SPACE};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cmd.sweep_run) begin
                idx_reg <= sweep_last ? '0 : idx_reg + tcw_pkg::IDX_W'(1);
            end
            pend_valid_reg <= cmd.sweep_run && !sweep_last;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= idx_reg[tcw_pkg::ADDR_W-1:0];
        pend_copy_reg <= rd_en;
    end

    always_ff @(posedge aclk) begin
        if (pend_valid_reg) begin
            mem[pend_addr_reg] <= pend_copy_reg ? rd_data_reg : fill_data;
        end else if (char_we) begin
            mem[old_pos] <= cell_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        sts.is_clear    = (in_reg.func == tcw_pkg::FUNC_CLEAR);
        sts.need_scroll = need_scroll;
        sts.sweep_done  = sweep_last;
        sts.out_free    = !m_valid_reg || m_ready;
    end

`ifndef SYNTHESIS
    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> !char_we)
        else $error("character write during store sweep");
    a_phase_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg == '0) |-> (phase_reg == '0))
        else $error("tab phase out of step with column");
`endif

endmodule

`default_nettype wire

// ===== src/tcw_ctrl.sv =====
// Controller of the text console writer: sequences accept, cursor step,
// store sweeps and result hand-off. Depends on tcw_pkg.
`default_nettype none

module tcw_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire tcw_pkg::sts_t  sts,
    output tcw_pkg::cmd_t       cmd
);

    tcw_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcw_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_INIT: begin
                if (sts.sweep_done) state_next = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_IDLE: begin
                if (s_valid) state_next = tcw_pkg::ST_CALC;
            end
            tcw_pkg::ST_CALC: begin
                priority if (sts.is_clear) state_next = tcw_pkg::ST_CLEAR;
                else if (sts.need_scroll)  state_next = tcw_pkg::ST_SCROLL;
                else                       state_next = tcw_pkg::ST_RESULT;
            end
            tcw_pkg::ST_CLEAR, tcw_pkg::ST_SCROLL: begin
                if (sts.sweep_done) state_next = tcw_pkg::ST_RESULT;
            end
            tcw_pkg::ST_RESULT: begin
                // next item may enter as the result leaves
                if (sts.out_free) begin
                    state_next = s_valid ? tcw_pkg::ST_CALC : tcw_pkg::ST_IDLE;
                end
            end
            default: state_next = tcw_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            tcw_pkg::ST_INIT: begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_init = 1'b1;
            end
            tcw_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            tcw_pkg::ST_CALC: begin
                cmd.calc = 1'b1;
            end
            tcw_pkg::ST_CLEAR: begin
                cmd.sweep_run = 1'b1;
            end
            tcw_pkg::ST_SCROLL: begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_copy = 1'b1;
            end
            tcw_pkg::ST_RESULT: begin
                s_ready      = sts.out_free;
                cmd.load_out = sts.out_free;
                cmd.accept   = sts.out_free && s_valid;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_calc_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcw_pkg::ST_CALC) |-> $past(cmd.accept))
        else $error("cursor step without an accepted item");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result overwrites an untaken result");
    a_sweep_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcw_pkg::ST_IDLE || state_reg == tcw_pkg::ST_CALC ||
         state_reg == tcw_pkg::ST_RESULT) |-> !sts.sweep_done)
        else $error("sweep counter moved outside a sweep");
`endif

endmodule

`default_nettype wire

// ===== src/text_console_writer_top.sv =====
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// Usage:
//   s_valid/s_ready/s_data carry one item: put a character or clear screen.
//   m_valid/m_ready/m_data carry one result per item: cursor after the item,
//   the cell stored (if any) and whether the screen scrolled.
//   cfg_we/cfg_wdata write the attribute byte, taken at once; write it only
//   while no item is in flight.
// Timing:
//   A plain put item is accepted, then stepped in ST_CALC, where its cell is written;
//   its result then goes to the output register, and the next item may be taken in that same cycle.
//   Clear and scroll walk the 2000-cell store through its single write port,
//   one cell per cycle, before the result goes to the output register.
// Reset:
//   aresetn homes the cursor, sets the attribute to 0x0F and runs a clearing
//   pass over the store; no item is taken during the pass.
// Stall:
//   The result waits in the output register; one more item is taken and
//   stepped, then s_ready drops until m_ready frees the register.
`default_nettype none

module text_console_writer_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire tcw_pkg::in_t                s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output tcw_pkg::out_t                    m_data,
    input  wire logic                        cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata
);

    tcw_pkg::cmd_t cmd;
    tcw_pkg::sts_t sts;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tcw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
